### hdl/dpbt_pkg.sv
// Package: sizes, operation codes, controller/datapath bundles and bit helpers.
`timescale 1ns / 1ps
package dpbt_pkg;

    localparam int WORD_BITS     = 32;
    localparam int WORD_IDX_BITS = $clog2(WORD_BITS);
    localparam int MAX_PAGES     = 65536;
    localparam int PAGE_BITS     = $clog2(MAX_PAGES);
    localparam int EXT_BITS      = PAGE_BITS + 1;
    localparam int NUM_WORDS     = MAX_PAGES / WORD_BITS;
    localparam int WADDR_BITS    = $clog2(NUM_WORDS);

    localparam int FUNC_BITS   = 2;
    localparam int OFFSET_BITS = 32;
    localparam int BCOUNT_BITS = 21;
    localparam int SHIFT_BITS  = 5;
    localparam int SHIFT_MIN   = 9;
    localparam int SHIFT_MAX   = 16;
    localparam int SHIFT_RESET = 12;

    localparam logic [FUNC_BITS-1:0] FUNC_MARK  = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_FIND  = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 2'd2;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic load;       // capture the accepted item
        logic decode;     // work out page and word bounds
        logic issue;      // read bitmap word at the word counter
        logic clr_write;  // write a zero word at the word counter
        logic emit;       // move the finished result to the output register
    } cmd_t;

    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic                 mark_skip;
        logic                 find_empty;
        logic                 clear_empty;
        logic                 issue_last;
        logic                 hit;
        logic                 pipe_idle;
        logic                 out_free;
    } stat_t;

    // Bits lo..hi of a word set, all others clear.
    function automatic word_t word_mask(input logic [WORD_IDX_BITS-1:0] lo,
                                        input logic [WORD_IDX_BITS-1:0] hi);
        word_t ones;
        ones = '1;
        return (ones << lo) & (ones >> (WORD_IDX_BITS'(WORD_BITS - 1) - hi));
    endfunction

    // Adder tree over the bits of a word.
    function automatic logic [WORD_IDX_BITS:0] popcount(input word_t w);
        logic [WORD_IDX_BITS:0] s [WORD_BITS];
        for (int i = 0; i < WORD_BITS; i++) begin
            s[i] = (WORD_IDX_BITS + 1)'(w[i]);
        end
        for (int lvl = 0; lvl < WORD_IDX_BITS; lvl++) begin
            for (int i = 0; i < (WORD_BITS >> (lvl + 1)); i++) begin
                s[i] = s[2 * i] + s[2 * i + 1];
            end
        end
        return s[0];
    endfunction

    // Position of the lowest set bit; zero when the word is zero.
    function automatic logic [WORD_IDX_BITS-1:0] low_index(input word_t w);
        word_t                    low;
        logic [WORD_IDX_BITS-1:0] idx;
        low = w & (~w + word_t'(1));
        idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            for (int k = 0; k < WORD_IDX_BITS; k++) begin
                if (((i >> k) & 1) == 1) begin
                    idx[k] = idx[k] | low[i];
                end
            end
        end
        return idx;
    endfunction

endpackage

### hdl/dpbt_if.sv
// Interfaces for the request and response channels.
`timescale 1ns / 1ps
interface dpbt_req_if
    import dpbt_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [FUNC_BITS-1:0]   func;
    logic [OFFSET_BITS-1:0] byte_offset;
    logic [BCOUNT_BITS-1:0] byte_count;
    logic [PAGE_BITS-1:0]   start_page;

    modport source (output valid, output func, output byte_offset, output byte_count,
                    output start_page, input ready);
    modport sink   (input valid, input func, input byte_offset, input byte_count,
                    input start_page, output ready);
endinterface

interface dpbt_rsp_if
    import dpbt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 status;
    logic                 found;
    logic [PAGE_BITS-1:0] page_number;
    logic [EXT_BITS-1:0]  dirty_total;
    logic [EXT_BITS-1:0]  extent_out;

    modport source (output valid, output status, output found, output page_number,
                    output dirty_total, output extent_out, input ready);
    modport sink   (input valid, input status, input found, input page_number,
                    input dirty_total, input extent_out, output ready);
endinterface

### hdl/dirty_page_bitmap_tracker_unit.sv
// Top level of the dirty page bitmap tracker: controller, datapath and channel wiring.
//
//   Channel   Direction  Handshake      Carries
//   req       in         valid/ready    func, byte_offset, byte_count, start_page
//   rsp       out        valid/ready    status, found, page_number, dirty_total, extent_out
//   cfg       in         cfg_wr_en      cfg_wr_data: page_shift
//
// One item is worked at a time through a single bitmap RAM port pair.
// Mark reads and writes back each bitmap word it touches (one read-modify-write a word).
// Find scans the words up to the hit or the extent.
// Clear writes zero to the words below the page extent.
// After reset a clearing pass zeroes the bitmap; req.ready stays low meanwhile.
// A stalled rsp holds its result while the next item is taken and worked.
`timescale 1ns / 1ps
module dirty_page_bitmap_tracker_unit
    import dpbt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [SHIFT_BITS-1:0] cfg_wr_data,
    dpbt_req_if.sink              req,
    dpbt_rsp_if.source            rsp
);

    cmd_t  cmd;
    stat_t stat;
    logic  ready;

    assign req.ready = ready;

    dpbt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .ready     (ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dpbt_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .req_func        (req.func),
        .req_byte_offset (req.byte_offset),
        .req_byte_count  (req.byte_count),
        .req_start_page  (req.start_page),
        .cmd             (cmd),
        .stat            (stat),
        .rsp             (rsp)
    );

endmodule

### hdl/dpbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dpbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/dpbt_ctrl.sv
// Controller state machine: sequences decode, word walks, drains and result hand-off.
`timescale 1ns / 1ps
module dpbt_ctrl
    import dpbt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_MARK   = 3'd3;
    localparam logic [2:0] S_FIND   = 3'd4;
    localparam logic [2:0] S_CLEAR  = 3'd5;
    localparam logic [2:0] S_DRAIN  = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr_write = 1'b1;
                if (stat.issue_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                unique case (stat.func)
                    FUNC_MARK:  state_next = stat.mark_skip   ? S_FINISH : S_MARK;
                    FUNC_FIND:  state_next = stat.find_empty  ? S_FINISH : S_FIND;
                    FUNC_CLEAR: state_next = stat.clear_empty ? S_FINISH : S_CLEAR;
                    default:    state_next = S_FINISH;
                endcase
            end
            S_MARK:
            begin
                cmd.issue = 1'b1;
                if (stat.issue_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_FIND:
            begin
                // A hit ends the walk; the datapath latches the page in the same cycle.
                if (stat.hit)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.issue = 1'b1;
                    if (stat.issue_last)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (stat.issue_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_DRAIN:
            begin
                if (stat.pipe_idle)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/dpbt_datapath.sv
// Datapath: bitmap RAM, page range decode, word read-modify-write, search and counters.
`timescale 1ns / 1ps
module dpbt_datapath
    import dpbt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [SHIFT_BITS-1:0]  cfg_wr_data,
    input  logic [FUNC_BITS-1:0]   req_func,
    input  logic [OFFSET_BITS-1:0] req_byte_offset,
    input  logic [BCOUNT_BITS-1:0] req_byte_count,
    input  logic [PAGE_BITS-1:0]   req_start_page,
    input  cmd_t                   cmd,
    output stat_t                  stat,
    dpbt_rsp_if.source             rsp
);

    localparam logic [SHIFT_BITS-1:0] SH_MIN = SHIFT_BITS'(SHIFT_MIN);
    localparam logic [SHIFT_BITS-1:0] SH_MAX = SHIFT_BITS'(SHIFT_MAX);

    // Configuration and persistent state.
    logic [SHIFT_BITS-1:0] shift_reg;
    logic [EXT_BITS-1:0]   extent_reg;
    logic [EXT_BITS-1:0]   dirty_reg;

    // Captured item.
    logic [FUNC_BITS-1:0]   func_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [BCOUNT_BITS-1:0] count_reg;
    logic [PAGE_BITS-1:0]   start_reg;

    // Word walk.
    logic [WADDR_BITS-1:0]    word_cnt_reg;
    logic [WADDR_BITS-1:0]    word_cnt_next;
    logic [WADDR_BITS-1:0]    first_word_reg;
    logic [WADDR_BITS-1:0]    end_word_reg;
    logic [WORD_IDX_BITS-1:0] lo_reg;
    logic [WORD_IDX_BITS-1:0] hi_reg;
    logic                     rd_vld_reg;
    logic [WADDR_BITS-1:0]    rd_word_reg;
    logic                     cnt_vld_reg;
    logic [WORD_IDX_BITS:0]   cnt_add_reg;

    // Result.
    logic                 status_reg;
    logic                 found_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic                 out_vld_reg;
    logic                 out_status_reg;
    logic                 out_found_reg;
    logic [PAGE_BITS-1:0] out_page_reg;
    logic [EXT_BITS-1:0]  out_dirty_reg;
    logic [EXT_BITS-1:0]  out_extent_reg;

    // Decode.
    logic [SHIFT_BITS-1:0]  sh;
    logic [OFFSET_BITS:0]   end_byte;
    logic [OFFSET_BITS-1:0] first_full;
    logic [OFFSET_BITS:0]   last_full;
    logic                   over;
    logic [PAGE_BITS-1:0]   first_page;
    logic [PAGE_BITS-1:0]   last_page;
    logic [EXT_BITS-1:0]    last_ext;
    logic [EXT_BITS-1:0]    ext_m1;
    logic                   mark_skip;

    // Word stage.
    word_t                    rdata;
    word_t                    mask;
    word_t                    hits;
    logic [WORD_IDX_BITS-1:0] lo_eff;
    logic [WORD_IDX_BITS-1:0] hi_eff;
    logic                     mark_wr;
    logic                     hit;
    logic                     ram_we;
    logic [WADDR_BITS-1:0]    ram_waddr;
    word_t                    ram_wdata;

    always_comb
    begin
        priority if (shift_reg < SH_MIN)
        begin
            sh = SH_MIN;
        end
        else if (shift_reg > SH_MAX)
        begin
            sh = SH_MAX;
        end
        else
        begin
            sh = shift_reg;
        end
    end

    // The last byte may carry into bit 32, so the end address is one bit wider.
    assign end_byte   = {1'b0, offset_reg} + (OFFSET_BITS + 1)'(count_reg)
                        - (OFFSET_BITS + 1)'(1);
    assign first_full = offset_reg >> sh;
    assign last_full  = end_byte >> sh;
    assign over       = last_full >= (OFFSET_BITS + 1)'(MAX_PAGES);
    assign first_page = first_full[PAGE_BITS-1:0];
    assign last_page  = last_full[PAGE_BITS-1:0];
    assign last_ext   = {1'b0, last_page} + EXT_BITS'(1);
    assign ext_m1     = extent_reg - EXT_BITS'(1);
    assign mark_skip  = (count_reg == '0) || over;

    // Only the first and last word of a walk are trimmed at their ends.
    assign lo_eff  = (rd_word_reg == first_word_reg) ? lo_reg : '0;
    assign hi_eff  = (rd_word_reg == end_word_reg) ? hi_reg : '1;
    assign mask    = word_mask(lo_eff, hi_eff);
    assign hits    = rdata & mask;
    assign mark_wr = rd_vld_reg && (func_reg == FUNC_MARK);
    assign hit     = rd_vld_reg && (func_reg == FUNC_FIND) && (hits != '0);

    assign ram_we    = mark_wr || cmd.clr_write;
    assign ram_waddr = mark_wr ? rd_word_reg : word_cnt_reg;
    assign ram_wdata = mark_wr ? (rdata | mask) : '0;

    dpbt_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (word_cnt_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        word_cnt_next = word_cnt_reg;
        if (cmd.decode)
        begin
            unique case (func_reg)
                FUNC_MARK: word_cnt_next = first_page[PAGE_BITS-1:WORD_IDX_BITS];
                FUNC_FIND: word_cnt_next = start_reg[PAGE_BITS-1:WORD_IDX_BITS];
                default:   word_cnt_next = '0;
            endcase
        end
        else if (cmd.issue || cmd.clr_write)
        begin
            word_cnt_next = word_cnt_reg + WADDR_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg    <= SHIFT_BITS'(SHIFT_RESET);
            extent_reg   <= '0;
            dirty_reg    <= '0;
            word_cnt_reg <= '0;
            end_word_reg <= WADDR_BITS'(NUM_WORDS - 1);
            rd_vld_reg   <= 1'b0;
            cnt_vld_reg  <= 1'b0;
            status_reg   <= 1'b0;
            found_reg    <= 1'b0;
            page_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                shift_reg <= cfg_wr_data;
            end
            word_cnt_reg <= word_cnt_next;
            rd_vld_reg   <= cmd.issue;
            cnt_vld_reg  <= mark_wr;

            if (cmd.decode)
            begin
                status_reg <= (func_reg == FUNC_MARK) && (count_reg != '0) && over;
                found_reg  <= 1'b0;
                page_reg   <= '0;
                unique case (func_reg)
                    FUNC_MARK:
                    begin
                        end_word_reg <= last_page[PAGE_BITS-1:WORD_IDX_BITS];
                        if (!mark_skip && (last_ext > extent_reg))
                        begin
                            extent_reg <= last_ext;
                        end
                    end
                    FUNC_FIND, FUNC_CLEAR:
                    begin
                        end_word_reg <= ext_m1[PAGE_BITS-1:WORD_IDX_BITS];
                    end
                    default:
                    begin
                        end_word_reg <= end_word_reg;
                    end
                endcase
            end
            else if (hit && !found_reg)
            begin
                found_reg <= 1'b1;
                page_reg  <= {rd_word_reg, low_index(hits)};
            end

            if (cmd.decode && (func_reg == FUNC_CLEAR))
            begin
                dirty_reg <= '0;
            end
            else if (cnt_vld_reg)
            begin
                dirty_reg <= dirty_reg + EXT_BITS'(cnt_add_reg);
            end

            if (cmd.emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= req_func;
            offset_reg <= req_byte_offset;
            count_reg  <= req_byte_count;
            start_reg  <= req_start_page;
        end
        if (cmd.decode)
        begin
            if (func_reg == FUNC_MARK)
            begin
                first_word_reg <= first_page[PAGE_BITS-1:WORD_IDX_BITS];
                lo_reg         <= first_page[WORD_IDX_BITS-1:0];
                hi_reg         <= last_page[WORD_IDX_BITS-1:0];
            end
            else
            begin
                first_word_reg <= start_reg[PAGE_BITS-1:WORD_IDX_BITS];
                lo_reg         <= start_reg[WORD_IDX_BITS-1:0];
                hi_reg         <= ext_m1[WORD_IDX_BITS-1:0];
            end
        end
        rd_word_reg <= word_cnt_reg;
        // Only pages that were clear before this write add to the count.
        cnt_add_reg <= popcount(mask & ~rdata);
        if (cmd.emit)
        begin
            out_status_reg <= status_reg;
            out_found_reg  <= found_reg;
            out_page_reg   <= page_reg;
            out_dirty_reg  <= dirty_reg;
            out_extent_reg <= extent_reg;
        end
    end

    assign stat.func        = func_reg;
    assign stat.mark_skip   = mark_skip;
    assign stat.find_empty  = {1'b0, start_reg} >= extent_reg;
    assign stat.clear_empty = (extent_reg == '0);
    assign stat.issue_last  = (word_cnt_reg == end_word_reg);
    assign stat.hit         = hit;
    assign stat.pipe_idle   = !rd_vld_reg && !cnt_vld_reg;
    assign stat.out_free    = !out_vld_reg || rsp.ready;

    assign rsp.valid       = out_vld_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.page_number = out_page_reg;
    assign rsp.dirty_total = out_dirty_reg;
    assign rsp.extent_out  = out_extent_reg;

    a_dirty_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dirty_reg <= EXT_BITS'(MAX_PAGES))
        else $error("dirty count above page capacity");

    a_found_below_extent: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> ({1'b0, page_reg} < extent_reg))
        else $error("found page at or above extent");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && cmd.issue) |-> (ram_waddr != word_cnt_reg))
        else $error("bitmap write and read hit the same word");

    a_clear_zeroes_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.decode && (func_reg == FUNC_CLEAR)) |=> (dirty_reg == '0))
        else $error("clear left a nonzero dirty count");

endmodule

### tb/dirty_page_bitmap_tracker_unit_test.sv
// Self-checking testbench for the dirty page bitmap tracker: directed and random items.
`timescale 1ns / 1ps
module dirty_page_bitmap_tracker_unit_test
    import dpbt_pkg::*;
;

    localparam logic [FUNC_BITS-1:0] FUNC_SPARE = 2'd3;

    localparam int PAGE_WINDOW     = 4096;
    localparam int PHASE_ITEMS     = 235;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int DRAIN_CYCLES    = 64;

    typedef struct packed {
        logic [FUNC_BITS-1:0]   func;
        logic [OFFSET_BITS-1:0] byte_offset;
        logic [BCOUNT_BITS-1:0] byte_count;
        logic [PAGE_BITS-1:0]   start_page;
    } tracker_req_t;

    typedef struct packed {
        logic                 status;
        logic                 found;
        logic [PAGE_BITS-1:0] page_number;
        logic [EXT_BITS-1:0]  dirty_total;
        logic [EXT_BITS-1:0]  extent_out;
    } tracker_rsp_t;

    typedef enum int unsigned {
        STALL_NONE,
        STALL_COIN,
        STALL_PATTERN,
        STALL_RARE
    } stall_mode_t;

    class dirty_map_scoreboard;
        word_t                 bitmap [NUM_WORDS];
        logic [EXT_BITS-1:0]   extent;
        logic [EXT_BITS-1:0]   dirty_pages;
        logic [SHIFT_BITS-1:0] page_shift;
        tracker_rsp_t          awaited [$];
        int                    errors;
        int                    marks;
        int                    rejects;
        int                    finds;
        int                    hits;
        int                    clears;
        int                    checked;

        function new();
            foreach (bitmap[i])
            begin
                bitmap[i] = '0;
            end
            extent      = '0;
            dirty_pages = '0;
            page_shift  = SHIFT_BITS'(SHIFT_RESET);
            errors      = 0;
            marks       = 0;
            rejects     = 0;
            finds       = 0;
            hits        = 0;
            clears      = 0;
            checked     = 0;
        endfunction

        // The register keeps all five bits; only the use is clamped.
        function int unsigned shift_in_use();
            if (page_shift < SHIFT_MIN)
            begin
                return SHIFT_MIN;
            end
            if (page_shift > SHIFT_MAX)
            begin
                return SHIFT_MAX;
            end
            return 32'(page_shift);
        endfunction

        function void note_request(tracker_req_t r);
            tracker_rsp_t res;
            logic [63:0]  first_pg;
            logic [63:0]  last_pg;
            int unsigned  p;
            res = '0;
            unique case (r.func)
                FUNC_MARK:
                begin
                    marks++;
                    if (r.byte_count != 0)
                    begin
                        first_pg = 64'(r.byte_offset) >> shift_in_use();
                        last_pg  = (64'(r.byte_offset) + 64'(r.byte_count) - 64'd1)
                                   >> shift_in_use();
                        if (last_pg >= 64'(MAX_PAGES))
                        begin
                            res.status = 1'b1;
                            rejects++;
                        end
                        else
                        begin
                            for (p = 32'(first_pg); p <= 32'(last_pg); p++)
                            begin
                                if (!bitmap[p / WORD_BITS][p % WORD_BITS])
                                begin
                                    bitmap[p / WORD_BITS][p % WORD_BITS] = 1'b1;
                                    dirty_pages++;
                                end
                            end
                            if (last_pg + 64'd1 > 64'(extent))
                            begin
                                extent = EXT_BITS'(last_pg + 64'd1);
                            end
                        end
                    end
                end
                FUNC_FIND:
                begin
                    finds++;
                    p = 32'(r.start_page);
                    while (p < extent && !res.found)
                    begin
                        // Skip the rest of a word that holds no dirty page at or above p.
                        if ((bitmap[p / WORD_BITS] >> (p % WORD_BITS)) == '0)
                        begin
                            p = (p / WORD_BITS + 1) * WORD_BITS;
                        end
                        else if (bitmap[p / WORD_BITS][p % WORD_BITS])
                        begin
                            res.found       = 1'b1;
                            res.page_number = PAGE_BITS'(p);
                            hits++;
                        end
                        else
                        begin
                            p++;
                        end
                    end
                end
                FUNC_CLEAR:
                begin
                    clears++;
                    foreach (bitmap[i])
                    begin
                        bitmap[i] = '0;
                    end
                    dirty_pages = '0;
                end
                default:
                begin
                end
            endcase
            res.dirty_total = dirty_pages;
            res.extent_out  = extent;
            awaited.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(tracker_rsp_t got);
            tracker_rsp_t want;
            if (awaited.size() == 0)
            begin
                $error("result arrived with no item outstanding");
                errors++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("found", 32'(want.found), 32'(got.found));
            compare_field("page_number", 32'(want.page_number), 32'(got.page_number));
            compare_field("dirty_total", 32'(want.dirty_total), 32'(got.dirty_total));
            compare_field("extent_out", 32'(want.extent_out), 32'(got.extent_out));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [SHIFT_BITS-1:0] cfg_wr_data;

    dpbt_req_if req_bus ();
    dpbt_rsp_if rsp_bus ();

    dirty_map_scoreboard sb;
    int                  burst_left;
    int                  shift_writes;
    int                  idle_cycles;

    dirty_page_bitmap_tracker_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_bus),
        .rsp         (rsp_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && req_bus.valid && req_bus.ready)
        begin
            sb.note_request(tracker_req_t'{req_bus.func, req_bus.byte_offset,
                                           req_bus.byte_count, req_bus.start_page});
        end
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            sb.check_result(tracker_rsp_t'{rsp_bus.status, rsp_bus.found,
                                           rsp_bus.page_number, rsp_bus.dirty_total,
                                           rsp_bus.extent_out});
        end
    end

    // Counts cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("[dirty_page_bitmap_tracker_unit] ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The receiver switches between stall styles over spans of random length.
    initial
    begin : receiver
        stall_mode_t mode;
        int unsigned span;
        int unsigned tick;
        int unsigned period;
        int unsigned stall_len;
        rsp_bus.ready = 1'b0;
        mode          = STALL_NONE;
        span          = 0;
        tick          = 0;
        period        = 2;
        stall_len     = 1;
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                mode      = stall_mode_t'($urandom_range(0, 3));
                span      = $urandom_range(50, 400);
                period    = $urandom_range(2, 12);
                stall_len = $urandom_range(1, period - 1);
                tick      = 0;
            end
            span--;
            tick++;
            unique case (mode)
                STALL_NONE:    rsp_bus.ready <= 1'b1;
                STALL_COIN:    rsp_bus.ready <= ($urandom_range(0, 1) == 1);
                STALL_PATTERN: rsp_bus.ready <= ((tick % period) >= stall_len);
                default:       rsp_bus.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    function automatic tracker_req_t req_of(logic [FUNC_BITS-1:0] func,
                                            logic [OFFSET_BITS-1:0] offset,
                                            logic [BCOUNT_BITS-1:0] count,
                                            logic [PAGE_BITS-1:0] start);
        tracker_req_t it;
        it.func        = func;
        it.byte_offset = offset;
        it.byte_count  = count;
        it.start_page  = start;
        return it;
    endfunction

    // Most marks land in a window of low pages so that the extent, and with it the
    // length of finds and clears, stays moderate until the closing items.
    function automatic tracker_req_t random_item();
        tracker_req_t it;
        int unsigned  roll;
        int unsigned  sh;
        int unsigned  pg;
        logic [63:0]  last_pg;
        it.func        = FUNC_BITS'($urandom);
        it.byte_offset = $urandom;
        it.byte_count  = BCOUNT_BITS'($urandom);
        it.start_page  = PAGE_BITS'($urandom);
        sh             = sb.shift_in_use();
        roll           = $urandom_range(0, 99);
        if (roll < 47)
        begin
            it.func        = FUNC_MARK;
            pg             = $urandom_range(0, PAGE_WINDOW - 1);
            it.byte_offset = OFFSET_BITS'((64'(pg) << sh)
                                          | (64'($urandom) & ((64'd1 << sh) - 64'd1)));
            case ($urandom_range(0, 9))
                0:       it.byte_count = '0;
                1, 2:    it.byte_count = BCOUNT_BITS'($urandom);
                3, 4:    it.byte_count = BCOUNT_BITS'($urandom_range(1, (1 << sh) * 8));
                default: it.byte_count = BCOUNT_BITS'($urandom_range(1, (1 << sh) * 2));
            endcase
        end
        else if (roll < 55)
        begin
            // Raw offsets: anything that would land far above the window is pushed past
            // capacity instead, which is rejected and leaves the extent alone.
            it.func = FUNC_MARK;
            if (it.byte_count != 0)
            begin
                last_pg = (64'(it.byte_offset) + 64'(it.byte_count) - 64'd1) >> sh;
                if (last_pg < 64'(MAX_PAGES) && last_pg >= 64'(2 * PAGE_WINDOW))
                begin
                    it.byte_offset = it.byte_offset | 32'hFFFF_0000;
                    it.byte_count  = '1;
                end
            end
        end
        else if (roll < 85)
        begin
            it.func = FUNC_FIND;
            case ($urandom_range(0, 9))
                0, 1:    it.start_page = '0;
                2:       it.start_page = PAGE_BITS'($urandom);
                default: it.start_page = PAGE_BITS'($urandom_range(0, sb.extent));
            endcase
        end
        else if (roll < 93)
        begin
            it.func = FUNC_CLEAR;
        end
        else
        begin
            it.func = FUNC_SPARE;
        end
        return it;
    endfunction

    task automatic send_item(input tracker_req_t it);
        req_bus.valid       <= 1'b1;
        req_bus.func        <= it.func;
        req_bus.byte_offset <= it.byte_offset;
        req_bus.byte_count  <= it.byte_count;
        req_bus.start_page  <= it.start_page;
        do @(posedge clk); while (!req_bus.ready);
        if (burst_left == 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(20, 80)
                                                    : $urandom_range(1, 8);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Every item returns a result, so an empty queue means the block is idle.
    // The wait before the queue check lets the scoreboard note an item taken at the edge just passed.
    task automatic settle();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic write_page_shift(input logic [SHIFT_BITS-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        sb.page_shift = value;
        shift_writes++;
    endtask

    initial
    begin : stimulus
        tracker_req_t head [$];
        int unsigned  shifts [$];
        int           done;
        tracker_req_t it;
        sb                  = new();
        burst_left          = 0;
        shift_writes        = 0;
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        req_bus.valid       = 1'b0;
        req_bus.func        = FUNC_MARK;
        req_bus.byte_offset = '0;
        req_bus.byte_count  = '0;
        req_bus.start_page  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Page size 4 KiB out of reset.
        head.push_back(req_of(FUNC_FIND, '0, '0, '0));
        head.push_back(req_of(FUNC_MARK, '0, '0, '0));
        head.push_back(req_of(FUNC_MARK, '0, 21'd1, '0));
        head.push_back(req_of(FUNC_MARK, '0, 21'd1, '0));
        head.push_back(req_of(FUNC_MARK, 32'd4095, 21'd2, '0));
        head.push_back(req_of(FUNC_MARK, 32'h0001_F000, 21'h2000, '0));
        head.push_back(req_of(FUNC_MARK, 32'hFFFF_FFFF, 21'd1, '0));
        head.push_back(req_of(FUNC_MARK, 32'h0FFF_F000, 21'h1001, '0));
        head.push_back(req_of(FUNC_MARK, '0, 21'h1F_FFFF, '0));
        head.push_back(req_of(FUNC_FIND, '0, '0, '0));
        head.push_back(req_of(FUNC_FIND, '0, '0, 16'hFFFF));
        head.push_back(req_of(FUNC_FIND, '0, '0, 16'd511));
        head.push_back(req_of(FUNC_FIND, '0, '0, 16'd512));
        head.push_back(req_of(FUNC_CLEAR, '1, '1, '1));
        head.push_back(req_of(FUNC_FIND, '0, '0, '0));
        head.push_back(req_of(FUNC_MARK, 32'h0020_0000, 21'd1, '0));
        head.push_back(req_of(FUNC_FIND, '0, '0, '0));
        head.push_back(req_of(FUNC_SPARE, '1, '1, '1));
        head.push_back(req_of(FUNC_MARK, 32'hFFFF_FFFF, '0, '0));
        head.push_back(req_of(FUNC_FIND, '1, '1, 16'd100));
        foreach (head[i])
        begin
            send_item(head[i]);
        end

        // A shift below the legal range behaves as 512-byte pages.
        settle();
        write_page_shift('0);
        send_item(req_of(FUNC_MARK, 32'h0000_01FF, 21'd2, '0));
        send_item(req_of(FUNC_FIND, '0, '0, '0));

        // A shift above the range behaves as 64 KiB pages; this one ends one page past capacity.
        settle();
        write_page_shift('1);
        send_item(req_of(FUNC_MARK, 32'hFFFF_FFFF, 21'd2, '0));

        shifts = '{16, 9, 0, 31, 13, $urandom_range(0, 31), $urandom_range(0, 31), 12};
        foreach (shifts[k])
        begin
            settle();
            write_page_shift(SHIFT_BITS'(shifts[k]));
            done = 0;
            while (done < PHASE_ITEMS)
            begin
                it = random_item();
                send_item(it);
                done++;
            end
        end

        // The last page of all raises the extent to its maximum, so it comes at the end.
        settle();
        write_page_shift(SHIFT_BITS'(SHIFT_MAX));
        send_item(req_of(FUNC_MARK, 32'hFFFF_FFFF, 21'd1, '0));
        send_item(req_of(FUNC_FIND, '0, '0, 16'hFFFF));
        send_item(req_of(FUNC_FIND, '0, '0, '0));
        send_item(req_of(FUNC_CLEAR, '0, '0, '0));
        send_item(req_of(FUNC_FIND, '0, '0, '0));

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d marks (%0d past capacity), %0d finds (%0d hits), %0d clears",
                 sb.marks, sb.rejects, sb.finds, sb.hits, sb.clears);
        $display("%0d results checked over %0d page-size writes, %0d mismatches",
                 sb.checked, shift_writes, sb.errors);
        if (sb.errors == 0 && sb.awaited.size() == 0)
        begin
            $display("[dirty_page_bitmap_tracker_unit] OK");
        end
        else
        begin
            $display("[dirty_page_bitmap_tracker_unit] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/dpbt_pkg.sv
hdl/dpbt_if.sv
hdl/dpbt_ram.sv
hdl/dpbt_ctrl.sv
hdl/dpbt_datapath.sv
hdl/dirty_page_bitmap_tracker_unit.sv
tb/dirty_page_bitmap_tracker_unit_test.sv
